@@ src/v2a_pkg.sv @@
// ----------------------------------------------------------------------------
// v2a_pkg
// Shared request codes, pipeline payload types and saturation helpers for the
// two-dimensional vector unit.
// ----------------------------------------------------------------------------
package v2a_pkg;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_SUB       = 3'd1;
  localparam logic [2:0] OP_SCALE     = 3'd2;
  localparam logic [2:0] OP_SQNORM    = 3'd3;
  localparam logic [2:0] OP_NORM      = 3'd4;
  localparam logic [2:0] OP_NORMALIZE = 3'd5;

  localparam int SQRT_STAGES = 32;
  localparam int QUOT_BITS   = 17;  // |u| <= length, so the quotient is at most 2^16

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // word carried down the long pipeline
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [63:0] sq;
    logic        ovf;
    logic [31:0] ux_mag;
    logic [31:0] uy_mag;
    logic        ux_neg;
    logic        uy_neg;
    logic [31:0] len;
  } meta_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [63:0] sq;
    logic [31:0] len;
    logic        ovf;
    logic        zerr;
  } res_t;

  // {overflow, clamped value} for a 33-bit sum
  function automatic logic [32:0] sat_sum(input logic [32:0] s);
    logic ovf;
    logic [31:0] val;
    ovf = s[32] ^ s[31];
    val = ovf ? (s[32] ? S32_MIN : S32_MAX) : s[31:0];
    return {ovf, val};
  endfunction

  // {overflow, clamped value} for a Q32.32 product taken to Q16.16 by floor
  function automatic logic [32:0] sat_prod(input logic [63:0] p);
    logic ovf;
    logic [31:0] val;
    ovf = !((p[63:47] == 17'h0) || (p[63:47] == 17'h1ffff));
    val = ovf ? (p[63] ? S32_MIN : S32_MAX) : p[47:16];
    return {ovf, val};
  endfunction

endpackage

@@ src/v2a_lane.sv @@
// ----------------------------------------------------------------------------
// v2a_lane
// One component lane: sum or difference, scale product and square of |u|.
// ----------------------------------------------------------------------------
module v2a_lane (
  input  logic               clk,
  input  logic               en,
  input  logic               sub,
  input  logic signed [31:0] u,
  input  logic signed [31:0] v,
  input  logic signed [31:0] k,
  output logic [32:0]        sum,
  output logic [63:0]        prod,
  output logic [63:0]        sq,
  output logic [31:0]        mag,
  output logic               neg
);

  logic signed [32:0] su, sv;
  logic [32:0] sum_next;
  logic [63:0] prod_next;
  logic [31:0] mag_next;

  always_comb begin
    su        = {u[31], u};
    sv        = {v[31], v};
    sum_next  = sub ? 33'(su - sv) : 33'(su + sv);
    prod_next = 64'(64'(u) * 64'(k));
    mag_next  = u[31] ? 32'(-u) : 32'(u);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= sum_next;
      prod <= prod_next;
      sq   <= 64'(mag_next) * 64'(mag_next);
      mag  <= mag_next;
      neg  <= u[31];
    end
  end

endmodule

@@ src/v2a_sqrt.sv @@
// ----------------------------------------------------------------------------
// v2a_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v2a_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_in,
  input  logic [63:0]   n_in,
  input  v2a_pkg::meta_t m_in,
  output logic          v_out,
  output v2a_pkg::meta_t m_out
);

  logic [63:0]    n_r   [1:v2a_pkg::SQRT_STAGES];
  logic [63:0]    res_r [1:v2a_pkg::SQRT_STAGES];
  v2a_pkg::meta_t m_r   [1:v2a_pkg::SQRT_STAGES];
  logic           v_r   [1:v2a_pkg::SQRT_STAGES];

  for (genvar j = 0; j < v2a_pkg::SQRT_STAGES; j++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0]    n_s, r_s, t;
    v2a_pkg::meta_t m_s;
    logic           v_s, ge;

    if (j == 0) begin : g_first
      assign n_s = n_in;
      assign r_s = 64'd0;
      assign m_s = m_in;
      assign v_s = v_in;
    end else begin : g_rest
      assign n_s = n_r[j];
      assign r_s = res_r[j];
      assign m_s = m_r[j];
      assign v_s = v_r[j];
    end

    assign t  = r_s + BIT;
    assign ge = n_s >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j+1]   <= ge ? n_s - t : n_s;
        res_r[j+1] <= ge ? (r_s >> 1) + BIT : r_s >> 1;
        m_r[j+1]   <= m_s;
      end
    end
  end

  assign v_out = v_r[v2a_pkg::SQRT_STAGES];

  always_comb begin
    m_out     = m_r[v2a_pkg::SQRT_STAGES];
    m_out.len = res_r[v2a_pkg::SQRT_STAGES][31:0];
  end

endmodule

@@ src/v2a_div_lane.sv @@
// ----------------------------------------------------------------------------
// v2a_div_lane
// Pipelined restoring divide of (|u| << 16) by the length, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module v2a_div_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [31:0]                    mag,
  input  logic [31:0]                    len,
  output logic [v2a_pkg::QUOT_BITS-1:0]  q
);

  localparam int NQ = v2a_pkg::QUOT_BITS;

  logic [47:0]   rem_r [1:NQ];
  logic [31:0]   len_r [1:NQ];
  logic [NQ-1:0] q_r   [1:NQ];

  for (genvar j = 0; j < NQ; j++) begin : g_st
    logic [47:0]   rem_s, d;
    logic [31:0]   len_s;
    logic [NQ-1:0] q_s;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_s = {mag, 16'h0};
      assign len_s = len;
      assign q_s   = '0;
    end else begin : g_rest
      assign rem_s = rem_r[j];
      assign len_s = len_r[j];
      assign q_s   = q_r[j];
    end

    assign d  = 48'(len_s) << (NQ - 1 - j);
    assign ge = rem_s >= d;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? rem_s - d : rem_s;
        len_r[j+1] <= len_s;
        q_r[j+1]   <= {q_s[NQ-2:0], ge};
      end
    end
  end

  assign q = q_r[NQ];

endmodule

@@ src/vec2_arith_unit.sv @@
// ----------------------------------------------------------------------------
// vec2_arith_unit
// Two-dimensional Q16.16 vector unit: add, subtract, scale, squared norm,
// norm and normalise, one request per cycle while the output buffer has room.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | req_type, ux, uy, vx, vy, scale_factor
//  out     | out_valid / out_ready| rx, ry, sq_norm, length, overflow, zero_error
//
// one word per cycle in and out while out_ready stays high; each request passes
// the lane stage, merge stage, 32 square root stages, 17 divide stages, output
// the depth is set by the bit-per-stage square root and divide pipelines
// a two-entry output buffer keeps the pipe moving while a result waits
// rst is synchronous and clears valid bits and the buffer; data regs hold
// ----------------------------------------------------------------------------
module vec2_arith_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] ux,
  input  logic [31:0] uy,
  input  logic [31:0] vx,
  input  logic [31:0] vy,
  input  logic [31:0] scale_factor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] rx,
  output logic [31:0] ry,
  output logic [63:0] sq_norm,
  output logic [31:0] length,
  output logic        overflow,
  output logic        zero_error
);

  localparam int DDEPTH = v2a_pkg::QUOT_BITS;

  logic en;
  logic acc;

  // lane stage
  logic        v1;
  logic [2:0]  op1;
  logic [32:0] sum_x, sum_y;
  logic [63:0] prod_x, prod_y, sq_x, sq_y;
  logic [31:0] mag_x, mag_y;
  logic        neg_x, neg_y;

  assign acc = in_valid && in_ready;

  v2a_lane u_lane_x (
    .clk (clk), .en (en), .sub (req_type == v2a_pkg::OP_SUB),
    .u (ux), .v (vx), .k (scale_factor),
    .sum (sum_x), .prod (prod_x), .sq (sq_x), .mag (mag_x), .neg (neg_x)
  );

  v2a_lane u_lane_y (
    .clk (clk), .en (en), .sub (req_type == v2a_pkg::OP_SUB),
    .u (uy), .v (vy), .k (scale_factor),
    .sum (sum_y), .prod (prod_y), .sq (sq_y), .mag (mag_y), .neg (neg_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= req_type;
    end
  end

  // merge stage
  logic [32:0]    sx_sat, sy_sat, px_sat, py_sat;
  logic [63:0]    sq_tot;
  v2a_pkg::meta_t m2_next, m2;
  logic [63:0]    n2;
  logic           v2;

  always_comb begin
    sx_sat = v2a_pkg::sat_sum(sum_x);
    sy_sat = v2a_pkg::sat_sum(sum_y);
    px_sat = v2a_pkg::sat_prod(prod_x);
    py_sat = v2a_pkg::sat_prod(prod_y);
    sq_tot = sq_x + sq_y;

    m2_next        = '0;
    m2_next.op     = op1;
    m2_next.ux_mag = mag_x;
    m2_next.uy_mag = mag_y;
    m2_next.ux_neg = neg_x;
    m2_next.uy_neg = neg_y;
    case (op1)
      v2a_pkg::OP_ADD, v2a_pkg::OP_SUB: begin
        m2_next.rx  = sx_sat[31:0];
        m2_next.ry  = sy_sat[31:0];
        m2_next.ovf = sx_sat[32] | sy_sat[32];
      end
      v2a_pkg::OP_SCALE: begin
        m2_next.rx  = px_sat[31:0];
        m2_next.ry  = py_sat[31:0];
        m2_next.ovf = px_sat[32] | py_sat[32];
      end
      v2a_pkg::OP_SQNORM: begin
        m2_next.sq = sq_tot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2 <= m2_next;
      n2 <= sq_tot;
    end
  end

  // square root
  logic           vs;
  v2a_pkg::meta_t ms;

  v2a_sqrt u_sqrt (
    .clk (clk), .rst (rst), .en (en),
    .v_in (v2), .n_in (n2), .m_in (m2),
    .v_out (vs), .m_out (ms)
  );

  // divide lanes and matching delay line
  logic [v2a_pkg::QUOT_BITS-1:0] qx, qy;
  v2a_pkg::meta_t                m_d [0:DDEPTH-1];
  logic [DDEPTH-1:0]             v_d;

  v2a_div_lane u_div_x (
    .clk (clk), .en (en), .mag (ms.ux_mag), .len (ms.len), .q (qx)
  );

  v2a_div_lane u_div_y (
    .clk (clk), .en (en), .mag (ms.uy_mag), .len (ms.len), .q (qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= '0;
    end else if (en) begin
      v_d <= {v_d[DDEPTH-2:0], vs};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_d[0] <= ms;
      for (int i = 1; i < DDEPTH; i++) begin
        m_d[i] <= m_d[i-1];
      end
    end
  end

  // final select
  v2a_pkg::meta_t mf;
  v2a_pkg::res_t  rf;
  logic           push, pop;

  always_comb begin
    mf      = m_d[DDEPTH-1];
    rf      = '0;
    rf.rx   = mf.rx;
    rf.ry   = mf.ry;
    rf.sq   = mf.sq;
    rf.ovf  = mf.ovf;
    case (mf.op)
      v2a_pkg::OP_NORM: begin
        rf.len = mf.len;
      end
      v2a_pkg::OP_NORMALIZE: begin
        if (mf.len == 32'd0) begin
          rf.zerr = 1'b1;
        end else begin
          rf.rx = mf.ux_neg ? 32'(-32'(qx)) : 32'(qx);
          rf.ry = mf.uy_neg ? 32'(-32'(qy)) : 32'(qy);
        end
      end
      default: begin
      end
    endcase
  end

  // two-entry output buffer
  v2a_pkg::res_t buf_r [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    cnt;

  assign en        = (cnt != 2'd2);
  assign in_ready  = en;
  assign push      = v_d[DDEPTH-1] && en;
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr] <= rf;
    end
  end

  assign rx         = buf_r[rd_ptr].rx;
  assign ry         = buf_r[rd_ptr].ry;
  assign sq_norm    = buf_r[rd_ptr].sq;
  assign length     = buf_r[rd_ptr].len;
  assign overflow   = buf_r[rd_ptr].ovf;
  assign zero_error = buf_r[rd_ptr].zerr;

endmodule

@@ src/v2a_checker.sv @@
// ----------------------------------------------------------------------------
// v2a_checker
// Port-level checks for the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module v2a_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rx,
  input logic [31:0] ry,
  input logic [63:0] sq_norm,
  input logic [31:0] length,
  input logic        overflow,
  input logic        zero_error
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(ry) && $stable(sq_norm))
    else $error("output word changed while stalled");

  // zero vector normalise gives a zero vector
  a_zerr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_error |-> rx == 32'd0 && ry == 32'd0 && !overflow)
    else $error("zero_error with nonzero result");

  // saturation only on vector ops
  a_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> sq_norm == 64'd0 && length == 32'd0 && !zero_error)
    else $error("overflow on scalar op");

  // norm result excludes the other scalar fields
  a_len_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && length != 32'd0 |-> sq_norm == 64'd0 && rx == 32'd0 && ry == 32'd0)
    else $error("length mixed with other fields");

endmodule

bind vec2_arith_unit v2a_checker u_v2a_checker (.*);

@@ verif/tb_vec2_arith_unit.sv @@
// ----------------------------------------------------------------------------
// tb_vec2_arith_unit
// Self-checking bench for the Q16.16 vector unit: directed corner words for
// every operation, then random traffic with random stalls on both sides, a
// long output hold-off that backs the pipe up, and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_vec2_arith_unit;

  typedef struct {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [63:0] sq;
    logic [31:0] len;
    logic        ovf;
    logic        zerr;
  } vec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [31:0] ux = '0, uy = '0, vx = '0, vy = '0, scale_factor = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] rx, ry, length;
  logic [63:0] sq_norm;
  logic        overflow, zero_error;

  vec_result_t expected_q[$];
  int  n_sent = 0, n_checked = 0, n_mismatch = 0, idle_cycles = 0;
  bit  allow_idle = 1'b1;
  bit  hold_off = 1'b0;
  int  op_count[8];

  vec2_arith_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] clamp32(input longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return v2a_pkg::S32_MAX;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return v2a_pkg::S32_MIN;
    end
    return v[31:0];
  endfunction

  // floor of the Q32.32 product taken down to Q16.16
  function automatic longint scale_q16(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] lo, hi, mid;
    lo = 0;
    hi = 64'd3037000500;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic vec_result_t predict_vec_op(input logic [2:0] op,
      input logic [31:0] a_x, a_y, b_x, b_y, k);
    vec_result_t r;
    longint sx, sy, bx, by, sk;
    logic [63:0] mx, my, l;
    r = '{default: '0};
    sx = longint'($signed(a_x));
    sy = longint'($signed(a_y));
    bx = longint'($signed(b_x));
    by = longint'($signed(b_y));
    sk = longint'($signed(k));
    mx = sx < 0 ? -sx : sx;
    my = sy < 0 ? -sy : sy;
    case (op)
      v2a_pkg::OP_ADD: begin
        r.rx = clamp32(sx + bx, r.ovf);
        r.ry = clamp32(sy + by, r.ovf);
      end
      v2a_pkg::OP_SUB: begin
        r.rx = clamp32(sx - bx, r.ovf);
        r.ry = clamp32(sy - by, r.ovf);
      end
      v2a_pkg::OP_SCALE: begin
        r.rx = clamp32(scale_q16(sk, sx), r.ovf);
        r.ry = clamp32(scale_q16(sk, sy), r.ovf);
      end
      v2a_pkg::OP_SQNORM: r.sq = mx * mx + my * my;
      v2a_pkg::OP_NORM:   r.len = 32'(int_sqrt(mx * mx + my * my));
      v2a_pkg::OP_NORMALIZE: begin
        l = int_sqrt(mx * mx + my * my);
        if (l == 0) r.zerr = 1'b1;
        else begin
          r.rx = 32'(sx < 0 ? -((mx << 16) / l) : (mx << 16) / l);
          r.ry = 32'(sy < 0 ? -((my << 16) / l) : (my << 16) / l);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [2:0] op,
      input logic [31:0] a_x, a_y, b_x, b_y, k);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= op;
    ux           <= a_x;
    uy           <= a_y;
    vx           <= b_x;
    vy           <= b_y;
    scale_factor <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_vec_op(op, a_x, a_y, b_x, b_y, k));
    op_count[op]++;
    n_sent++;
  endtask

  // random operand biased toward small values, zero and the extremes
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? v2a_pkg::S32_MAX : v2a_pkg::S32_MIN;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000);
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] corner[6];
    corner = '{32'h0, 32'h1, 32'hffff_ffff, v2a_pkg::S32_MAX, v2a_pkg::S32_MIN,
               32'h0001_0000};
    send_word(v2a_pkg::OP_ADD, v2a_pkg::S32_MAX, v2a_pkg::S32_MIN, 32'h1,
              32'hffff_ffff, 0);
    send_word(v2a_pkg::OP_ADD, 32'h1234_5678, 32'hf000_0000, 32'h0000_1000,
              32'h0fff_ffff, 0);
    send_word(v2a_pkg::OP_SUB, v2a_pkg::S32_MIN, v2a_pkg::S32_MAX, 32'h1,
              32'hffff_ffff, 0);
    send_word(v2a_pkg::OP_SUB, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
              32'h5555_5555, 0);
    send_word(v2a_pkg::OP_SCALE, v2a_pkg::S32_MAX, v2a_pkg::S32_MIN, 0, 0,
              v2a_pkg::S32_MIN);
    send_word(v2a_pkg::OP_SCALE, 32'hffff_ffff, 32'h1, 0, 0, 32'h0000_8000);
    send_word(v2a_pkg::OP_SCALE, 32'h0003_0000, 32'hfffd_0000, 0, 0, 32'h0001_8000);
    send_word(v2a_pkg::OP_SCALE, v2a_pkg::S32_MAX, 32'h1, 0, 0, v2a_pkg::S32_MAX);
    foreach (corner[i]) begin
      send_word(v2a_pkg::OP_SQNORM, corner[i], corner[(i + 3) % 6], 0, 0, 0);
      send_word(v2a_pkg::OP_NORM, corner[i], corner[(i + 1) % 6], 0, 0, 0);
    end
    send_word(v2a_pkg::OP_NORM, v2a_pkg::S32_MIN, v2a_pkg::S32_MIN, 0, 0, 0);
    send_word(v2a_pkg::OP_SQNORM, v2a_pkg::S32_MIN, v2a_pkg::S32_MIN, 0, 0, 0);
    send_word(v2a_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0);
    send_word(v2a_pkg::OP_NORMALIZE, v2a_pkg::S32_MIN, 32'h1, 0, 0, 0);
    send_word(v2a_pkg::OP_NORMALIZE, 32'hffff_ffff, 0, 0, 0, 0);
    send_word(3'd6, v2a_pkg::S32_MAX, v2a_pkg::S32_MAX, v2a_pkg::S32_MAX,
              v2a_pkg::S32_MAX, v2a_pkg::S32_MAX);
    send_word(3'd7, v2a_pkg::S32_MIN, 32'h1, 32'h1, 32'h1, 32'h1);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_word($urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5)),
                rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
  endtask

  // output side holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(120);
      begin
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  // receiver with random stall bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    vec_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word from output");
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (rx !== e.rx || ry !== e.ry || sq_norm !== e.sq || length !== e.len ||
            overflow !== e.ovf || zero_error !== e.zerr) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch word %0d: exp rx=%h ry=%h sq=%h len=%h ovf=%b zerr=%b",
                     n_checked, e.rx, e.ry, e.sq, e.len, e.ovf, e.zerr,
                     "\n                 got rx=%h ry=%h sq=%h len=%h ovf=%b zerr=%b",
                     rx, ry, sq_norm, length, overflow, zero_error);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 2000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_random(600);
    allow_idle = 1'b0;
    test_random(200);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d of %0d words: add %0d sub %0d scale %0d sqnorm %0d",
             n_checked, n_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("norm %0d normalize %0d unused codes %0d, with stalls and a long hold-off",
             op_count[4], op_count[5], op_count[6] + op_count[7]);
    if (n_mismatch == 0 && expected_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
